// ===== design/olst_pkg.sv =====
// ----------------------------------------------------------------------------
// olst_pkg
// Shared types and codes for the ordered list engine: payload structs,
// operation and status codes, and the store command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package olst_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int COUNT_W  = 5;
   localparam int WORD_W   = 32;

   localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

   // Operation codes carried in the kind field.
   localparam logic [2:0] KIND_INS_FRONT  = 3'd0;
   localparam logic [2:0] KIND_INS_BACK   = 3'd1;
   localparam logic [2:0] KIND_INS_AFTER  = 3'd2;
   localparam logic [2:0] KIND_INS_BEFORE = 3'd3;
   localparam logic [2:0] KIND_DELETE     = 3'd4;
   localparam logic [2:0] KIND_SEARCH     = 3'd5;

   // Result status codes.
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [2:0]               kind;
      logic signed [WORD_W-1:0] key;
      logic signed [WORD_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [COUNT_W-1:0] count;
   } rsp_payload_type;

   typedef struct packed {
      logic               we;
      logic [IDX_W-1:0]   waddr;
      logic [WORD_W-1:0]  wdata;
      logic [IDX_W-1:0]   raddr;
   } store_cmd_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type data;
   } fin_type;

endpackage

`default_nettype wire

// ===== design/olst_store.sv =====
// ----------------------------------------------------------------------------
// olst_store
// Entry memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module olst_store (
   input  wire logic                           clock,
   input  wire olst_pkg::store_cmd_type        cmd,
   output logic [olst_pkg::WORD_W-1:0]         rdata
);

   logic [olst_pkg::WORD_W-1:0] mem [olst_pkg::CAPACITY];
   logic [olst_pkg::WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.waddr] <= cmd.wdata;
      end
      rdata_ff <= mem[cmd.raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/olst_seq.sv =====
// ----------------------------------------------------------------------------
// olst_seq
// Operation sequencer: scans the store with a single key comparator, then
// moves entries one at a time to open or close a gap.
// ----------------------------------------------------------------------------
`default_nettype none

module olst_seq (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire olst_pkg::req_payload_type    req_data,
   output olst_pkg::store_cmd_type           cmd,
   input  wire logic [olst_pkg::WORD_W-1:0]  rdata,
   output olst_pkg::fin_type                 fin,
   input  wire logic                         fin_take
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_INS_RD = 3'd2;
   localparam logic [2:0] S_INS_WR = 3'd3;
   localparam logic [2:0] S_DEL_RD = 3'd4;
   localparam logic [2:0] S_DEL_WR = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   localparam int CW = olst_pkg::COUNT_W;
   localparam logic [CW-1:0] ONE = CW'(1);

   logic [2:0]                   state_ff,  state_in;
   logic [2:0]                   kind_ff,   kind_in;
   logic [olst_pkg::WORD_W-1:0]  key_ff,    key_in;
   logic [olst_pkg::WORD_W-1:0]  value_ff,  value_in;
   logic [CW-1:0]                ptr_ff,    ptr_in;
   logic [CW-1:0]                pos_ff,    pos_in;
   logic                         pend_ff,   pend_in;
   logic [CW-1:0]                count_ff,  count_in;
   logic [1:0]                   status_ff, status_in;

   logic          hit;
   logic [CW-1:0] hit_pos;
   logic [CW-1:0] ptr_dec;
   logic [CW-1:0] ptr_inc;

   // The one comparator: stored word against the key, bit for bit.
   assign hit     = pend_ff && (rdata == key_ff);
   assign hit_pos = ptr_ff - ONE;
   assign ptr_dec = ptr_ff - ONE;
   assign ptr_inc = ptr_ff + ONE;

   assign req_ready       = (state_ff == S_IDLE);
   assign fin.valid       = (state_ff == S_DONE);
   assign fin.data.status = status_ff;
   assign fin.data.count  = count_ff;

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      key_in    = key_ff;
      value_in  = value_ff;
      ptr_in    = ptr_ff;
      pos_in    = pos_ff;
      pend_in   = pend_ff;
      count_in  = count_ff;
      status_in = status_ff;
      cmd.we    = 1'b0;
      cmd.waddr = ptr_ff[olst_pkg::IDX_W-1:0];
      cmd.wdata = rdata;
      cmd.raddr = ptr_ff[olst_pkg::IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in  = req_data.kind;
               key_in   = $unsigned(req_data.key);
               value_in = $unsigned(req_data.value);
               ptr_in   = '0;
               pend_in  = 1'b0;
               case (req_data.kind) inside
                  olst_pkg::KIND_INS_FRONT, olst_pkg::KIND_INS_BACK: begin
                     if (count_ff == olst_pkg::CAP_COUNT) begin
                        status_in = olst_pkg::STATUS_FULL;
                        state_in  = S_DONE;
                     end else begin
                        pos_in   = (req_data.kind == olst_pkg::KIND_INS_FRONT) ?
                                   '0 : count_ff;
                        ptr_in   = count_ff;
                        state_in = S_INS_RD;
                     end
                  end
                  olst_pkg::KIND_INS_AFTER, olst_pkg::KIND_INS_BEFORE,
                  olst_pkg::KIND_DELETE, olst_pkg::KIND_SEARCH: begin
                     if (count_ff == '0) begin
                        status_in = olst_pkg::STATUS_MISS;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     status_in = olst_pkg::STATUS_MISS;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // Reads are issued one per cycle; each compare sees the word read
            // in the cycle before, at position ptr_ff - 1.
            if (hit) begin
               case (kind_ff)
                  olst_pkg::KIND_SEARCH: begin
                     status_in = olst_pkg::STATUS_OK;
                     state_in  = S_DONE;
                  end
                  olst_pkg::KIND_DELETE: begin
                     ptr_in   = hit_pos;
                     state_in = S_DEL_RD;
                  end
                  olst_pkg::KIND_INS_AFTER, olst_pkg::KIND_INS_BEFORE: begin
                     if (count_ff == olst_pkg::CAP_COUNT) begin
                        status_in = olst_pkg::STATUS_FULL;
                        state_in  = S_DONE;
                     end else begin
                        pos_in   = (kind_ff == olst_pkg::KIND_INS_AFTER) ?
                                   hit_pos + ONE : hit_pos;
                        ptr_in   = count_ff;
                        state_in = S_INS_RD;
                     end
                  end
                  default: begin
                     status_in = olst_pkg::STATUS_MISS;
                     state_in  = S_DONE;
                  end
               endcase
            end else if (ptr_ff == count_ff) begin
               status_in = olst_pkg::STATUS_MISS;
               state_in  = S_DONE;
            end else begin
               ptr_in  = ptr_inc;
               pend_in = 1'b1;
            end
         end

         S_INS_RD: begin
            if (ptr_ff == pos_ff) begin
               cmd.we    = 1'b1;
               cmd.waddr = pos_ff[olst_pkg::IDX_W-1:0];
               cmd.wdata = value_ff;
               count_in  = count_ff + ONE;
               status_in = olst_pkg::STATUS_OK;
               state_in  = S_DONE;
            end else begin
               cmd.raddr = ptr_dec[olst_pkg::IDX_W-1:0];
               state_in  = S_INS_WR;
            end
         end

         S_INS_WR: begin
            cmd.we   = 1'b1;
            ptr_in   = ptr_dec;
            state_in = S_INS_RD;
         end

         S_DEL_RD: begin
            if (ptr_inc < count_ff) begin
               cmd.raddr = ptr_inc[olst_pkg::IDX_W-1:0];
               state_in  = S_DEL_WR;
            end else begin
               count_in  = count_ff - ONE;
               status_in = olst_pkg::STATUS_OK;
               state_in  = S_DONE;
            end
         end

         S_DEL_WR: begin
            cmd.we   = 1'b1;
            ptr_in   = ptr_inc;
            state_in = S_DEL_RD;
         end

         S_DONE: begin
            if (fin_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      kind_ff   <= kind_in;
      key_ff    <= key_in;
      value_ff  <= value_in;
      ptr_ff    <= ptr_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
   end

endmodule

`default_nettype wire

// ===== design/ordered_list_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of signed 32-bit values with insert, delete and search.
// ----------------------------------------------------------------------------
// The engine accepts one request at a time. A keyed operation scans from the
// head, one entry per cycle through a single comparator on an entry memory
// with one read port. Inserts and deletes then move every entry behind the
// gap, one read and then one write per entry, so a front insert moves every
// entry while a back insert moves none. The finished result is then handed to
// the output register, which lets the next request start while a result still
// waits on rsp_ready.
`default_nettype none

module ordered_list_engine (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire olst_pkg::req_payload_type    req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output olst_pkg::rsp_payload_type         rsp_data
);

   olst_pkg::store_cmd_type     cmd;
   logic [olst_pkg::WORD_W-1:0] rdata;
   olst_pkg::fin_type           fin;
   logic                        fin_take;

   logic                        rsp_valid_ff, rsp_valid_in;
   olst_pkg::rsp_payload_type   rsp_data_ff,  rsp_data_in;

   olst_store u_store (
      .clock (clock),
      .cmd   (cmd),
      .rdata (rdata)
   );

   olst_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd       (cmd),
      .rdata     (rdata),
      .fin       (fin),
      .fin_take  (fin_take)
   );

   // The output slot is free when empty or when its transfer completes now.
   assign fin_take = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fin.valid && fin_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = fin.data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the ordered list engine against a behavioral list kept in the bench.
// It runs directed cases (empty list, value extremes, every operation, full
// list), then random operation mixes under four idling profiles. Each result
// is compared with the predicted status and count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int PHASE_ITEMS    = 260;
   localparam int BLOCK_ITEMS    = 52;

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   olst_pkg::req_payload_type req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   olst_pkg::rsp_payload_type rsp_data;

   // Behavioral copy of the list: position 0 is the head.
   logic [olst_pkg::WORD_W-1:0] list_words [olst_pkg::CAPACITY];
   int                          list_count;

   olst_pkg::rsp_payload_type predicted_rsp_q [$];
   int                        error_count   = 0;
   int                        send_idle_pct = 0;
   int                        rsp_stall_pct = 0;
   int                        quiet_cycles  = 0;

   ordered_list_engine u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic logic [1:0] insert_word(int pos,
                                              logic [olst_pkg::WORD_W-1:0] word);
      if (list_count >= olst_pkg::CAPACITY) return olst_pkg::STATUS_FULL;
      for (int i = list_count; i > pos; i--) list_words[i] = list_words[i-1];
      list_words[pos] = word;
      list_count++;
      return olst_pkg::STATUS_OK;
   endfunction

   function automatic logic [1:0] remove_word(int pos);
      if (pos < 0) return olst_pkg::STATUS_MISS;
      for (int i = pos; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
      list_count--;
      return olst_pkg::STATUS_OK;
   endfunction

   function automatic olst_pkg::rsp_payload_type apply_list_op(
      olst_pkg::req_payload_type item);
      olst_pkg::rsp_payload_type outcome;
      int                        hit;
      hit = -1;
      for (int i = 0; i < list_count; i++) begin
         if (hit < 0 && list_words[i] == item.key) hit = i;
      end
      case (item.kind)
         olst_pkg::KIND_INS_FRONT:  outcome.status = insert_word(0, item.value);
         olst_pkg::KIND_INS_BACK:   outcome.status = insert_word(list_count, item.value);
         olst_pkg::KIND_INS_AFTER:  outcome.status = (hit < 0) ? olst_pkg::STATUS_MISS
                                                      : insert_word(hit + 1, item.value);
         olst_pkg::KIND_INS_BEFORE: outcome.status = (hit < 0) ? olst_pkg::STATUS_MISS
                                                      : insert_word(hit, item.value);
         olst_pkg::KIND_DELETE:     outcome.status = remove_word(hit);
         olst_pkg::KIND_SEARCH:     outcome.status = (hit < 0) ? olst_pkg::STATUS_MISS
                                                               : olst_pkg::STATUS_OK;
         default:                   outcome.status = olst_pkg::STATUS_MISS;
      endcase
      outcome.count = olst_pkg::COUNT_W'(list_count);
      return outcome;
   endfunction

   // Valid stays high from one transfer to the next unless an idle gap is drawn.
   task automatic send_request(input olst_pkg::req_payload_type item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(negedge clock); while (!req_ready);
      predicted_rsp_q.push_back(apply_list_op(item));
      @(posedge clock);
   endtask

   task automatic send_op(input logic [2:0] kind,
                          input logic [olst_pkg::WORD_W-1:0] key,
                          input logic [olst_pkg::WORD_W-1:0] value);
      olst_pkg::req_payload_type item;
      item.kind  = kind;
      item.key   = key;
      item.value = value;
      send_request(item);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_rsp_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [olst_pkg::WORD_W-1:0] pick_word();
      case ($urandom_range(7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         4, 5:    return olst_pkg::WORD_W'($urandom_range(3));
         default: return $urandom;
      endcase
   endfunction

   // Samples at the falling edge, so the transfer happens at the next rising edge.
   always @(negedge clock) begin : check_results
      olst_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_rsp_q.size() == 0) begin
            $error("unexpected result: status %0d count %0d", rsp_data.status,
                   rsp_data.count);
            error_count++;
         end else begin
            want = predicted_rsp_q.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.count !== want.count) begin
               $error("count: expected %0d, actual %0d", want.count, rsp_data.count);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      wait (reset == 1'b0);
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(negedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   task automatic test_empty_list();
      send_op(olst_pkg::KIND_DELETE, 32'd5, 32'd0);
      send_op(olst_pkg::KIND_INS_BEFORE, 32'd5, 32'd9);
      send_op(olst_pkg::KIND_SEARCH, 32'd0, 32'd0);
   endtask

   task automatic test_extremes_and_kinds();
      send_op(olst_pkg::KIND_INS_FRONT, 32'hDEAD_BEEF, 32'h8000_0000);
      send_op(olst_pkg::KIND_INS_BACK, 32'h0, 32'h7FFF_FFFF);
      send_op(olst_pkg::KIND_INS_AFTER, 32'h8000_0000, 32'h0);
      // Inserting before the head entry makes the new value the head.
      send_op(olst_pkg::KIND_INS_BEFORE, 32'h8000_0000, 32'hFFFF_FFFF);
      send_op(olst_pkg::KIND_SEARCH, 32'h7FFF_FFFF, 32'h0);
      send_op(3'd6, 32'h0, 32'hFFFF_FFFF);
      send_op(3'd7, 32'hFFFF_FFFF, 32'h0);
      send_op(olst_pkg::KIND_DELETE, 32'hFFFF_FFFF, 32'h0);
      send_op(olst_pkg::KIND_DELETE, 32'h1234_5678, 32'h0);
   endtask

   task automatic test_fill_to_capacity();
      // Repeated zeros give keyed operations several matches; the model takes the first from the head.
      while (list_count + predicted_rsp_q.size() < olst_pkg::CAPACITY + 4 &&
             list_count < olst_pkg::CAPACITY)
         send_op(olst_pkg::KIND_INS_BACK, 32'h0, 32'h0);
      send_op(olst_pkg::KIND_INS_FRONT, 32'h0, 32'h5555_5555);
      send_op(olst_pkg::KIND_INS_BEFORE, 32'h0, 32'hAAAA_AAAA);
      send_op(olst_pkg::KIND_INS_AFTER, 32'h0BAD_CAFE, 32'h1);
      send_op(olst_pkg::KIND_DELETE, 32'h0, 32'h0);
   endtask

   task automatic test_random_traffic(input int items, input bit pause_midway);
      olst_pkg::req_payload_type item;
      int                        sent;
      int                        insert_pct;
      int                        roll;
      sent = 0;
      insert_pct = 50;
      while (sent < items) begin
         if (sent % BLOCK_ITEMS == 0) insert_pct = $urandom_range(15, 85);
         if (pause_midway && sent == items / 2) wait_drained();
         roll = $urandom_range(99);
         if (roll < 2) item.kind = 3'($urandom_range(6, 7));
         else if (roll < insert_pct) item.kind = 3'($urandom_range(0, 3));
         else item.kind = $urandom_range(1) ? olst_pkg::KIND_DELETE
                                            : olst_pkg::KIND_SEARCH;
         if (list_count > 0 && $urandom_range(3) != 0)
            item.key = list_words[$urandom_range(list_count - 1)];
         else
            item.key = pick_word();
         item.value = pick_word();
         send_request(item);
         if (item.kind <= olst_pkg::KIND_SEARCH) sent++;
      end
   endtask

   initial begin : run
      int stall_profile [4][2];
      stall_profile = '{'{0, 0}, '{88, 0}, '{0, 88}, '{35, 35}};
      list_count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_list();
      test_extremes_and_kinds();
      test_fill_to_capacity();
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = stall_profile[p][0];
         rsp_stall_pct = stall_profile[p][1];
         test_random_traffic(PHASE_ITEMS, p == 1);
         wait_drained();
      end

      rsp_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && predicted_rsp_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
